>>> hdl/pbfm_pkg.sv
package pbfm_pkg;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	// command codes carried on s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_GET   = 2'd0,
		CMD_PUT   = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// result codes carried on m_tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT        = 3'd0,
		ST_MISS       = 3'd1,
		ST_BUSY       = 3'd2,
		ST_NO_VICTIM  = 3'd3,
		ST_RELEASED   = 3'd4,
		ST_FLUSHED    = 3'd5,
		ST_CLOSE_DONE = 3'd6
	} status_t;

endpackage

>>> hdl/page_buffer_frame_manager_unit.sv
// Channel | Dir | Handshake          | Payload (lowest bit first)
// s_*     | in  | s_tvalid/s_tready  | tuser: command; tdata: table, page, frame_index
// m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: frame_out, writeback_valid,
//         |     |                    |   writeback_table, writeback_page, fill_valid; tlast: last
// cfg_*   | in  | cfg_we             | cfg_data: frames_in_use
//
// n = active frame count. Tags and ages live in one RAM (registered read, one write port).
// get: one pipelined tag scan over n frames, then a recency pass over n frames unless the
//   hit is busy or there is no victim. put: releases one frame. close: reads and checks
//   each frame, plus an age pass over n frames for each frame that is dropped.
// One item at a time; s_tready is high only when idle. A waiting result in the output
// register does not block the next beat, only the next result. Reset clears all valid,
// dirty and pinned bits at once; no clearing pass.
module page_buffer_frame_manager_unit
	import pbfm_pkg::*;
#(
	parameter int FRAMES     = 64,
	parameter int TABLE_BITS = 4,
	parameter int PAGE_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [$clog2(FRAMES+1)-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: table_number, page_number, frame_index
	input  logic [((TABLE_BITS+PAGE_BITS+$clog2(FRAMES)+7)/8)*8-1:0] s_tdata,
	// tuser: command
	input  logic [CMD_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: frame_out, writeback_valid, writeback_table, writeback_page, fill_valid
	output logic [((TABLE_BITS+PAGE_BITS+$clog2(FRAMES)+2+7)/8)*8-1:0] m_tdata,
	// tuser: status
	output logic [STATUS_W-1:0] m_tuser,
	output logic m_tlast
);

	localparam int FI    = $clog2(FRAMES);
	localparam int CNT_W = $clog2(FRAMES+1);
	localparam int AW    = $clog2(FRAMES);
	localparam int MW    = TABLE_BITS + PAGE_BITS + AW;
	localparam int OUT_USED = FI + 2 + TABLE_BITS + PAGE_BITS;
	localparam int OUT_W = ((OUT_USED+7)/8)*8;
	localparam logic [AW-1:0]    AGE_MAX  = AW'(FRAMES-1);
	localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);

	typedef struct packed {
		status_t               status;
		logic [FI-1:0]         frame;
		logic                  wbv;
		logic [TABLE_BITS-1:0] wbt;
		logic [PAGE_BITS-1:0]  wbp;
		logic                  fill;
		logic                  last;
	} res_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SCAN  = 11'b00000000010,
		S_DEC   = 11'b00000000100,
		S_TOUCH = 11'b00000001000,
		S_TWR   = 11'b00000010000,
		S_EMIT  = 11'b00000100000,
		S_CRD   = 11'b00001000000,
		S_CCHK  = 11'b00010000000,
		S_CDEC  = 11'b00100000000,
		S_CEND  = 11'b01000000000,
		S_PUT   = 11'b10000000000
	} state_t;

	state_t state_q, ret_q;
	logic [CNT_W-1:0] frames_q;
	logic [FRAMES-1:0] valid_q, dirty_q, pinned_q;

	logic [MW-1:0] mem [FRAMES];
	logic [MW-1:0] mem_rd_q;

	logic [TABLE_BITS-1:0] tbl_q;
	logic [PAGE_BITS-1:0]  pg_q;
	logic [FI-1:0]         idx_q;

	logic [CNT_W-1:0] pcnt_q;
	logic             rd_v_s1;
	logic [FI-1:0]    rd_idx_s1;

	logic                  hit_v_q, free_v_q, lru_v_q, miss_q;
	logic [FI-1:0]         hit_idx_q, free_idx_q, lru_idx_q, e_q, ci_q;
	logic [AW-1:0]         hit_age_q, lru_age_q, cage_q;
	logic [TABLE_BITS-1:0] lru_tbl_q;
	logic [PAGE_BITS-1:0]  lru_pg_q;
	logic [AW:0]           old_q;

	res_t res_q, held_q, out_q;
	logic held_v_q, out_v_q;

	// active frame count, clamped to 1..FRAMES
	logic [CNT_W-1:0] n_act;
	logic [FI-1:0]    n_last;
	always_comb begin
		if (frames_q == '0) begin
			n_act = CNT_W'(1);
		end else if (frames_q > FRAMES_C) begin
			n_act = FRAMES_C;
		end else begin
			n_act = frames_q;
		end
		n_last = FI'(n_act - CNT_W'(1));
	end

	// read data fields
	logic [AW-1:0]         rd_age;
	logic [PAGE_BITS-1:0]  rd_pg;
	logic [TABLE_BITS-1:0] rd_tbl;
	assign rd_age = mem_rd_q[AW-1:0];
	assign rd_pg  = mem_rd_q[AW +: PAGE_BITS];
	assign rd_tbl = mem_rd_q[AW+PAGE_BITS +: TABLE_BITS];

	logic in_pass, pass_done;
	assign in_pass   = (state_q == S_SCAN) || (state_q == S_TOUCH) || (state_q == S_CDEC);
	assign pass_done = rd_v_s1 && (rd_idx_s1 == n_last);

	// read port address
	logic          rd_en;
	logic [FI-1:0] rd_addr;
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pcnt_q[FI-1:0];
		if (in_pass) begin
			rd_en = pcnt_q < n_act;
		end else if (state_q == S_CRD) begin
			rd_en   = 1'b1;
			rd_addr = ci_q;
		end
	end

	// write port: age updates in the passes, tag with age zero for the chosen frame of a get
	logic          we;
	logic [FI-1:0] waddr;
	logic [MW-1:0] wdata;
	logic [AW-1:0] age_inc;
	assign age_inc = (rd_age == AGE_MAX) ? rd_age : rd_age + AW'(1);
	always_comb begin
		we    = 1'b0;
		waddr = rd_idx_s1;
		wdata = {rd_tbl, rd_pg, age_inc};
		case (state_q)
			S_TOUCH: begin
				we = rd_v_s1 && (rd_idx_s1 != e_q) && valid_q[rd_idx_s1]
					&& ({1'b0, rd_age} < old_q);
			end
			S_CDEC: begin
				we    = rd_v_s1 && (rd_idx_s1 != ci_q) && valid_q[rd_idx_s1]
					&& (rd_age > cage_q);
				wdata = {rd_tbl, rd_pg, rd_age - AW'(1)};
			end
			S_TWR: begin
				we    = 1'b1;
				waddr = e_q;
				wdata = {tbl_q, pg_q, AW'(0)};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// tag and age RAM
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	logic [TABLE_BITS-1:0] in_tbl;
	logic [PAGE_BITS-1:0]  in_pg;
	logic [FI-1:0]         in_idx;
	assign in_tbl = s_tdata[TABLE_BITS-1:0];
	assign in_pg  = s_tdata[TABLE_BITS +: PAGE_BITS];
	assign in_idx = s_tdata[TABLE_BITS+PAGE_BITS +: FI];

	assign s_tready = (state_q == S_IDLE);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			frames_q  <= FRAMES_C;
			valid_q   <= '0;
			dirty_q   <= '0;
			pinned_q  <= '0;
			tbl_q     <= '0;
			pg_q      <= '0;
			idx_q     <= '0;
			pcnt_q    <= '0;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
			hit_v_q   <= 1'b0;
			free_v_q  <= 1'b0;
			lru_v_q   <= 1'b0;
			miss_q    <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			lru_idx_q <= '0;
			e_q       <= '0;
			ci_q      <= '0;
			hit_age_q <= '0;
			lru_age_q <= '0;
			cage_q    <= '0;
			lru_tbl_q <= '0;
			lru_pg_q  <= '0;
			old_q     <= '0;
			res_q     <= '0;
			held_q    <= '0;
			held_v_q  <= 1'b0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_q <= cfg_data;
			end

			// pass read pipeline
			rd_v_s1   <= in_pass && rd_en;
			rd_idx_s1 <= rd_addr;
			if (in_pass && rd_en) begin
				pcnt_q <= pcnt_q + CNT_W'(1);
			end

			// output register drains; S_EMIT refills it itself
			if (out_v_q && m_tready && (state_q != S_EMIT)) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						tbl_q <= in_tbl;
						pg_q  <= in_pg;
						idx_q <= in_idx;
						case (s_tuser)
							CMD_GET: begin
								hit_v_q  <= 1'b0;
								free_v_q <= 1'b0;
								lru_v_q  <= 1'b0;
								pcnt_q   <= '0;
								state_q  <= S_SCAN;
							end
							CMD_PUT: begin
								state_q <= S_PUT;
							end
							CMD_CLOSE: begin
								ci_q     <= '0;
								held_v_q <= 1'b0;
								state_q  <= S_CRD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_PUT: begin
					if ((CNT_W'(idx_q) < n_act) && valid_q[idx_q]) begin
						pinned_q[idx_q] <= 1'b0;
						dirty_q[idx_q]  <= 1'b1;
					end
					res_q   <= '{ST_RELEASED, idx_q, 1'b0, '0, '0, 1'b0, 1'b1};
					ret_q   <= S_IDLE;
					state_q <= S_EMIT;
				end

				// tag scan: first hit, first free frame, oldest unpinned frame
				S_SCAN: begin
					if (rd_v_s1) begin
						if (valid_q[rd_idx_s1] && rd_tbl == tbl_q && rd_pg == pg_q
							&& !hit_v_q) begin
							hit_v_q   <= 1'b1;
							hit_idx_q <= rd_idx_s1;
							hit_age_q <= rd_age;
						end
						if (!valid_q[rd_idx_s1] && !free_v_q) begin
							free_v_q   <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (!pinned_q[rd_idx_s1] && (!lru_v_q || rd_age > lru_age_q)) begin
							lru_v_q   <= 1'b1;
							lru_idx_q <= rd_idx_s1;
							lru_age_q <= rd_age;
							lru_tbl_q <= rd_tbl;
							lru_pg_q  <= rd_pg;
						end
					end
					if (pass_done) begin
						state_q <= S_DEC;
					end
				end

				S_DEC: begin
					pcnt_q <= '0;
					ret_q  <= S_IDLE;
					if (hit_v_q) begin
						if (pinned_q[hit_idx_q]) begin
							res_q   <= '{ST_BUSY, hit_idx_q, 1'b0, '0, '0, 1'b0, 1'b1};
							state_q <= S_EMIT;
						end else begin
							pinned_q[hit_idx_q] <= 1'b1;
							e_q     <= hit_idx_q;
							old_q   <= {1'b0, hit_age_q};
							miss_q  <= 1'b0;
							res_q   <= '{ST_HIT, hit_idx_q, 1'b0, '0, '0, 1'b0, 1'b1};
							state_q <= S_TOUCH;
						end
					end else if (free_v_q) begin
						e_q     <= free_idx_q;
						old_q   <= (AW+1)'(FRAMES);
						miss_q  <= 1'b1;
						res_q   <= '{ST_MISS, free_idx_q, 1'b0, '0, '0, 1'b1, 1'b1};
						state_q <= S_TOUCH;
					end else if (lru_v_q) begin
						e_q     <= lru_idx_q;
						old_q   <= {1'b0, lru_age_q};
						miss_q  <= 1'b1;
						if (dirty_q[lru_idx_q]) begin
							res_q <= '{ST_MISS, lru_idx_q, 1'b1, lru_tbl_q, lru_pg_q, 1'b1, 1'b1};
						end else begin
							res_q <= '{ST_MISS, lru_idx_q, 1'b0, '0, '0, 1'b1, 1'b1};
						end
						state_q <= S_TOUCH;
					end else begin
						res_q   <= '{ST_NO_VICTIM, '0, 1'b0, '0, '0, 1'b0, 1'b1};
						state_q <= S_EMIT;
					end
				end

				// recency pass: ages are written back by the write port
				S_TOUCH: begin
					if (pass_done) begin
						state_q <= S_TWR;
					end
				end

				S_TWR: begin
					if (miss_q) begin
						valid_q[e_q]  <= 1'b1;
						dirty_q[e_q]  <= 1'b0;
						pinned_q[e_q] <= 1'b1;
					end
					state_q <= S_EMIT;
				end

				S_EMIT: begin
					if (!out_v_q || m_tready) begin
						out_q   <= res_q;
						out_v_q <= 1'b1;
						state_q <= ret_q;
					end
				end

				S_CRD: begin
					state_q <= S_CCHK;
				end

				// close: check one frame, hold its flush so the last one can be marked
				S_CCHK: begin
					pcnt_q <= '0;
					if (valid_q[ci_q] && rd_tbl == tbl_q) begin
						cage_q <= rd_age;
						if (dirty_q[ci_q]) begin
							held_q   <= '{ST_FLUSHED, ci_q, 1'b1, rd_tbl, rd_pg, 1'b0, 1'b0};
							held_v_q <= 1'b1;
							if (held_v_q) begin
								res_q   <= held_q;
								ret_q   <= S_CDEC;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_CDEC;
							end
						end else begin
							state_q <= S_CDEC;
						end
					end else if (ci_q == n_last) begin
						state_q <= S_CEND;
					end else begin
						ci_q    <= ci_q + FI'(1);
						state_q <= S_CRD;
					end
				end

				// close up the ages above the dropped frame
				S_CDEC: begin
					if (pass_done) begin
						valid_q[ci_q]  <= 1'b0;
						dirty_q[ci_q]  <= 1'b0;
						pinned_q[ci_q] <= 1'b0;
						if (ci_q == n_last) begin
							state_q <= S_CEND;
						end else begin
							ci_q    <= ci_q + FI'(1);
							state_q <= S_CRD;
						end
					end
				end

				S_CEND: begin
					if (held_v_q) begin
						res_q <= '{held_q.status, held_q.frame, held_q.wbv, held_q.wbt,
							held_q.wbp, held_q.fill, 1'b1};
					end else begin
						res_q <= '{ST_CLOSE_DONE, '0, 1'b0, '0, '0, 1'b0, 1'b1};
					end
					held_v_q <= 1'b0;
					ret_q    <= S_IDLE;
					state_q  <= S_EMIT;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat
	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;
	assign m_tdata  = OUT_W'({out_q.fill, out_q.wbp, out_q.wbt, out_q.wbv, out_q.frame});

endmodule
